// File: rtl/core/ictf_pkg.sv
// Shared types and constants for the IMU complementary tilt filter.
// No dependencies; imported by every module of the block.
package ictf_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned ATAN_LEN        = 24;
  localparam int unsigned TBL_IDX_W       = 5;
  localparam int unsigned XY_W            = 35;
  localparam int unsigned Z_W             = 27;

  // 180 degrees in angle format
  localparam logic signed [Z_W-1:0] HALF_TURN = 27'sd11796480;

  // atan(2^-i) in degrees, ANGLE_FRAC_BITS fraction bits, rounded
  localparam logic [21:0] ATAN_STEP [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  typedef enum logic [2:0] {
    REG_UPPER_X = 3'd0,
    REG_LOWER_X = 3'd1,
    REG_UPPER_Y = 3'd2,
    REG_LOWER_Y = 3'd3,
    REG_UPPER_Z = 3'd4,
    REG_LOWER_Z = 3'd5,
    REG_GYRO_G  = 3'd6,
    REG_BLEND_G = 3'd7
  } ictf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TILT_GO,
    ST_TILT_WAIT,
    ST_UPD_GO,
    ST_UPD_WAIT,
    ST_OUT
  } ictf_state_e;

  typedef enum logic [1:0] {
    PH_GYRO,
    PH_BLEND,
    PH_SUM
  } ictf_phase_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_INIT   = 1'b1
  } ictf_op_e;

  function automatic logic signed [16:0] dead_band(input logic signed [15:0] g,
                                                   input logic signed [15:0] up,
                                                   input logic signed [15:0] lo);
    logic signed [16:0] r;
    r = '0;
    if (g > up) begin
      r = {g[15], g} - {up[15], up};
    end else if (g < lo) begin
      r = {g[15], g} - {lo[15], lo};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ictf_cordic.sv
// Iterative vectoring CORDIC atan2 in degrees, one rotation per cycle.
// Depends on ictf_pkg for the arctangent table and widths.
module ictf_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  y_i,
  input  logic signed [15:0]  x_i,
  output logic                done_o,
  output logic signed [24:0]  angle_o
);
  import ictf_pkg::*;

  localparam int unsigned CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic                    zero_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [XY_W-1:0]  x_q, y_q;
  logic signed [Z_W-1:0]   z_q;
  logic signed [16:0]      xe, ye, xa, ya;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [Z_W-1:0]   step, z_cl;

  assign xe   = {x_i[15], x_i};
  assign ye   = {y_i[15], y_i};
  assign xa   = x_i[15] ? -xe : xe;
  assign ya   = x_i[15] ? -ye : ye;
  assign dx   = y_q >>> cnt_q;
  assign dy   = x_q >>> cnt_q;
  assign step = Z_W'(ATAN_STEP[TBL_IDX_W'(cnt_q)]);

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == 16'sd0) && (y_i == 16'sd0);
      x_q    <= {{(XY_W-33){xa[16]}}, xa, 16'b0};
      y_q    <= {{(XY_W-33){ya[16]}}, ya, 16'b0};
      if (x_i[15]) begin
        z_q <= y_i[15] ? -HALF_TURN : HALF_TURN;
      end else begin
        z_q <= '0;
      end
    end else if (run_q) begin
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + step;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - step;
      end
    end
  end

  always_comb begin
    z_cl = z_q;
    if (z_q > HALF_TURN) begin
      z_cl = HALF_TURN;
    end else if (z_q < -HALF_TURN) begin
      z_cl = -HALF_TURN;
    end
  end

  assign done_o  = done_q;
  assign angle_o = zero_q ? 25'sd0 : z_cl[24:0];

endmodule

// File: rtl/core/ictf_mac.sv
// Angle update for one axis on one shared multiplier: gyro term, blend term,
// then saturating sum. Depends on ictf_pkg.
module ictf_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [16:0]  rate_i,
  input  logic signed [24:0]  tilt_i,
  input  logic signed [31:0]  stored_i,
  input  logic [31:0]         gain_i,
  input  logic [16:0]         blend_i,
  output logic                done_o,
  output logic signed [31:0]  angle_o
);
  import ictf_pkg::*;

  logic                run_q, done_q;
  ictf_phase_e         ph_q;
  logic signed [33:0]  tg_q, tb_q;
  logic signed [31:0]  res_q;
  logic [16:0]         blend_c;
  logic signed [32:0]  diff, mul_a, mul_b;
  logic signed [65:0]  prod;
  logic signed [35:0]  sum;

  // blend gains above one act as one
  assign blend_c = (blend_i > 17'd65536) ? 17'd65536 : blend_i;
  assign diff    = {{8{tilt_i[24]}}, tilt_i} - {stored_i[31], stored_i};

  always_comb begin
    if (ph_q == PH_GYRO) begin
      mul_a = {{16{rate_i[16]}}, rate_i};
      mul_b = {1'b0, gain_i};
    end else begin
      mul_a = diff;
      mul_b = {16'b0, blend_c};
    end
  end

  assign prod = mul_a * mul_b;
  assign sum  = {{4{stored_i[31]}}, stored_i} + {{2{tg_q[33]}}, tg_q}
              + {{2{tb_q[33]}}, tb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PH_GYRO;
    end else begin
      done_q <= !start_i && run_q && (ph_q == PH_SUM);
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= PH_GYRO;
      end else if (run_q) begin
        unique case (ph_q)
          PH_GYRO:  ph_q <= PH_BLEND;
          PH_BLEND: ph_q <= PH_SUM;
          PH_SUM: begin
            ph_q   <= PH_GYRO;
            run_q  <= 1'b0;
          end
          default:  ph_q <= PH_GYRO;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      if (ph_q == PH_GYRO) begin
        tg_q <= prod[49:16];
      end
      if (ph_q == PH_BLEND) begin
        tb_q <= prod[49:16];
      end
      if (ph_q == PH_SUM) begin
        if (sum > 36'sh07FFFFFFF) begin
          res_q <= 32'sh7FFFFFFF;
        end else if (sum < -36'sh080000000) begin
          res_q <= 32'sh80000000;
        end else begin
          res_q <= sum[31:0];
        end
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = res_q;

endmodule

// File: rtl/core/imu_complementary_tilt_filter.sv
// Top level of the IMU complementary tilt filter: register port, sequencer,
// dead band and stored angles. Uses ictf_pkg, ictf_cordic and ictf_mac.
//
//  channel | signals                          | word
//  --------+----------------------------------+--------------------------------
//  in      | in_valid_i / in_stall_o          | operation, accel xyz, gyro xyz
//  out     | out_valid_o / out_stall_i        | angle xyz, tilt xyz, rate xyz
//  cfg     | psel penable pwrite paddr pwdata | eight gain/threshold registers
//
// An initialize word skips the update step and so ends sooner than an update;
// the atan2 unit iterates one rotation per cycle. in_stall_o is high while a
// word is in work. The output register takes the result when free; while the
// output stalls, the finished word waits in ST_OUT and the input stays stalled.
// Reset clears the registers and the stored angles to zero.
module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic signed [15:0]  gyro_x_i,
  input  logic signed [15:0]  gyro_y_i,
  input  logic signed [15:0]  gyro_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  angle_x_o,
  output logic signed [31:0]  angle_y_o,
  output logic signed [31:0]  angle_z_o,
  output logic signed [24:0]  tilt_x_o,
  output logic signed [24:0]  tilt_y_o,
  output logic signed [24:0]  tilt_z_o,
  output logic signed [16:0]  rate_x_o,
  output logic signed [16:0]  rate_y_o,
  output logic signed [16:0]  rate_z_o
);
  import ictf_pkg::*;

  logic signed [15:0] upper_q [3];
  logic signed [15:0] lower_q [3];
  logic [31:0]        gyro_gain_q;
  logic [16:0]        blend_gain_q;
  ictf_reg_e          reg_idx;
  logic               cfg_wr;

  ictf_state_e        state_q, state_d;
  logic [1:0]         axis_q, axis_d;
  logic               in_acc, out_free;
  ictf_op_e           op_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] rate_q  [3];
  logic signed [24:0] tilt_q  [3];
  logic signed [31:0] stored_q [3];

  logic               cor_start, cor_done;
  logic signed [15:0] cor_y, cor_x;
  logic signed [24:0] cor_angle;
  logic               mac_start, mac_done;
  logic signed [31:0] mac_angle;
  logic               out_valid_q;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = ictf_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        upper_q[i] <= '0;
        lower_q[i] <= '0;
      end
      gyro_gain_q  <= '0;
      blend_gain_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_UPPER_X: upper_q[0]   <= pwdata[15:0];
        REG_LOWER_X: lower_q[0]   <= pwdata[15:0];
        REG_UPPER_Y: upper_q[1]   <= pwdata[15:0];
        REG_LOWER_Y: lower_q[1]   <= pwdata[15:0];
        REG_UPPER_Z: upper_q[2]   <= pwdata[15:0];
        REG_LOWER_Z: lower_q[2]   <= pwdata[15:0];
        REG_GYRO_G:  gyro_gain_q  <= pwdata;
        REG_BLEND_G: blend_gain_q <= pwdata[16:0];
        default:     gyro_gain_q  <= gyro_gain_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UPPER_X: prdata = {16'b0, upper_q[0]};
      REG_LOWER_X: prdata = {16'b0, lower_q[0]};
      REG_UPPER_Y: prdata = {16'b0, upper_q[1]};
      REG_LOWER_Y: prdata = {16'b0, lower_q[1]};
      REG_UPPER_Z: prdata = {16'b0, upper_q[2]};
      REG_LOWER_Z: prdata = {16'b0, lower_q[2]};
      REG_GYRO_G:  prdata = gyro_gain_q;
      REG_BLEND_G: prdata = {15'b0, blend_gain_q};
      default:     prdata = '0;
    endcase
  end

  // sequencer
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    cor_start = 1'b0;
    mac_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_TILT_GO;
          axis_d  = 2'd0;
        end
      end
      ST_TILT_GO: begin
        cor_start = 1'b1;
        state_d   = ST_TILT_WAIT;
      end
      ST_TILT_WAIT: begin
        if (cor_done) begin
          if (op_q == OP_INIT) begin
            state_d = (axis_q == 2'd2) ? ST_OUT : ST_TILT_GO;
            axis_d  = (axis_q == 2'd2) ? axis_q : axis_q + 2'd1;
          end else begin
            state_d = ST_UPD_GO;
          end
        end
      end
      ST_UPD_GO: begin
        mac_start = 1'b1;
        state_d   = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (mac_done) begin
          state_d = (axis_q == 2'd2) ? ST_OUT : ST_TILT_GO;
          axis_d  = (axis_q == 2'd2) ? axis_q : axis_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // captured word and dead band
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= ictf_op_e'(operation_i);
      ax_q      <= accel_x_i;
      ay_q      <= accel_y_i;
      az_q      <= accel_z_i;
      rate_q[0] <= dead_band(gyro_x_i, upper_q[0], lower_q[0]);
      rate_q[1] <= dead_band(gyro_y_i, upper_q[1], lower_q[1]);
      rate_q[2] <= dead_band(gyro_z_i, upper_q[2], lower_q[2]);
    end
    if ((state_q == ST_TILT_WAIT) && cor_done) begin
      tilt_q[axis_q] <= cor_angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        stored_q[i] <= '0;
      end
    end else begin
      if ((state_q == ST_TILT_WAIT) && cor_done && (op_q == OP_INIT)) begin
        stored_q[axis_q] <= {{7{cor_angle[24]}}, cor_angle};
      end
      if ((state_q == ST_UPD_WAIT) && mac_done) begin
        stored_q[axis_q] <= mac_angle;
      end
    end
  end

  // X: atan2(ay,az), Y: atan2(ax,az), Z: atan2(ax,ay)
  always_comb begin
    unique case (axis_q)
      2'd0:    begin cor_y = ay_q; cor_x = az_q; end
      2'd1:    begin cor_y = ax_q; cor_x = az_q; end
      default: begin cor_y = ax_q; cor_x = ay_q; end
    endcase
  end

  ictf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  ictf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .rate_i   (rate_q[axis_q]),
    .tilt_i   (tilt_q[axis_q]),
    .stored_i (stored_q[axis_q]),
    .gain_i   (gyro_gain_q),
    .blend_i  (blend_gain_q),
    .done_o   (mac_done),
    .angle_o  (mac_angle)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      angle_x_o <= stored_q[0];
      angle_y_o <= stored_q[1];
      angle_z_o <= stored_q[2];
      tilt_x_o  <= tilt_q[0];
      tilt_y_o  <= tilt_q[1];
      tilt_z_o  <= tilt_q[2];
      rate_x_o  <= rate_q[0];
      rate_y_o  <= rate_q[1];
      rate_z_o  <= rate_q[2];
    end
  end

  assign out_valid_o = out_valid_q;

  a_cor_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == ST_TILT_WAIT))
    else $error("atan2 result outside its wait state");

  a_mac_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_UPD_WAIT))
    else $error("update result outside its wait state");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3)
    else $error("axis counter out of range");

  a_init_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_GO) |-> (op_q == OP_UPDATE))
    else $error("update started for an initialize word");

endmodule
